// ===== hdl/bitmap_flag_engine_assert.svh =====
// Assertion macros used by the bitmap flag engine core.
`ifndef BITMAP_FLAG_ENGINE_ASSERT_SVH
`define BITMAP_FLAG_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BFE_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BFE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bfe_pkg.sv =====
`timescale 1ns / 1ps

package bfe_pkg;

  localparam int MAX_BITS = 1024;
  localparam int WORD_W   = 32;
  localparam int WORDS    = MAX_BITS / WORD_W;
  localparam int ADDR_W   = $clog2(WORDS);
  localparam int BIT_W    = $clog2(WORD_W);
  localparam int IDX_W    = 10;
  localparam int LEN_W    = 11;
  localparam int CNT_W    = 11;
  localparam int POP_W    = $clog2(WORD_W + 1);
  localparam int NW_W     = LEN_W - BIT_W;

  typedef enum logic [3:0] {
    REQ_SET         = 4'd0,
    REQ_CLEAR       = 4'd1,
    REQ_TOGGLE      = 4'd2,
    REQ_TEST        = 4'd3,
    REQ_SET_ALL     = 4'd4,
    REQ_CLEAR_ALL   = 4'd5,
    REQ_COUNT_SET   = 4'd6,
    REQ_COUNT_CLEAR = 4'd7,
    REQ_FIND_SET    = 4'd8,
    REQ_FIND_CLEAR  = 4'd9
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BOUNDS   = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MODIFY,
    S_BULK,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             bit_value;
    logic [CNT_W-1:0] bit_count;
    logic [IDX_W-1:0] found_index;
  } res_t;

endpackage

// ===== hdl/bitmap_flag_engine.sv =====
// Channel    Handshake             Payload
// request    in_valid / in_ready   req_type, bit_index
// result     out_valid / out_ready status, bit_value, bit_count, found_index
// config     cfg_wr_en             cfg_wr_data (active length)
//
// In-bounds single-bit requests pass a read state and a modify state: a read and a
// write-back through the one flag memory, with no write-back for a test request.
// Out-of-bounds and unknown requests go straight to the result. Count and find
// requests walk the covering words at one memory read per cycle; set-all and
// clear-all write one word per cycle. One request is in flight at a time; the next
// is taken while a result waits in the output register. Synchronous reset clears the
// flag store through per-word valid bits at once and sets the length to 1024; a
// stalled result holds the engine.
`timescale 1ns / 1ps

module bitmap_flag_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [bfe_pkg::LEN_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [3:0]                 req_type,
  input  logic [bfe_pkg::IDX_W-1:0]  bit_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic                       bit_value,
  output logic [bfe_pkg::CNT_W-1:0]  bit_count,
  output logic [bfe_pkg::IDX_W-1:0]  found_index
);

  logic [bfe_pkg::LEN_W-1:0] active_bits;
  logic [bfe_pkg::LEN_W-1:0] len;
  logic                      res_valid;
  logic                      res_ready;
  bfe_pkg::res_t             res;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bits <= bfe_pkg::LEN_W'(bfe_pkg::MAX_BITS);
    end else if (cfg_wr_en) begin
      active_bits <= cfg_wr_data;
    end
  end

  // Lengths above the store size are clamped to it.
  assign len = (active_bits > bfe_pkg::LEN_W'(bfe_pkg::MAX_BITS)) ?
               bfe_pkg::LEN_W'(bfe_pkg::MAX_BITS) : active_bits;

  bfe_core u_core (
    .clk       (clk),
    .rst       (rst),
    .len       (len),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .bit_index (bit_index),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  bfe_obuf u_obuf (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .bit_value   (bit_value),
    .bit_count   (bit_count),
    .found_index (found_index)
  );

endmodule

// ===== hdl/bfe_ram.sv =====
`timescale 1ns / 1ps

module bfe_ram (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        we,
  input  logic [bfe_pkg::ADDR_W-1:0]  waddr,
  input  logic [bfe_pkg::WORD_W-1:0]  wdata,
  input  logic [bfe_pkg::ADDR_W-1:0]  raddr,
  output logic [bfe_pkg::WORD_W-1:0]  rdata
);

  logic [bfe_pkg::WORD_W-1:0] mem [bfe_pkg::WORDS];
  logic [bfe_pkg::WORDS-1:0]  written;
  logic [bfe_pkg::WORD_W-1:0] rd_word;
  logic                       rd_written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_word <= mem[raddr];
  end

  // A word never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      rd_written <= written[raddr];
    end
  end

  assign rdata = rd_written ? rd_word : '0;

endmodule

// ===== hdl/bfe_core.sv =====
`timescale 1ns / 1ps
`include "bitmap_flag_engine_assert.svh"

module bfe_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [bfe_pkg::LEN_W-1:0]         len,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [3:0]                        req_type,
  input  logic [bfe_pkg::IDX_W-1:0]         bit_index,
  output logic                              res_valid,
  input  logic                              res_ready,
  output bfe_pkg::res_t                     res
);

  function automatic logic [bfe_pkg::POP_W-1:0] pop32(input logic [bfe_pkg::WORD_W-1:0] v);
    logic [bfe_pkg::POP_W-1:0] c;
    c = '0;
    for (int b = 0; b < bfe_pkg::WORD_W; b++) begin
      c = c + {{(bfe_pkg::POP_W-1){1'b0}}, v[b]};
    end
    return c;
  endfunction

  function automatic logic [bfe_pkg::BIT_W-1:0] lowest(input logic [bfe_pkg::WORD_W-1:0] v);
    logic [bfe_pkg::BIT_W-1:0] p;
    p = '0;
    for (int b = bfe_pkg::WORD_W - 1; b >= 0; b--) begin
      if (v[b]) begin
        p = b[bfe_pkg::BIT_W-1:0];
      end
    end
    return p;
  endfunction

  bfe_pkg::state_t state, state_next;

  logic [3:0]                   req_q;
  logic [bfe_pkg::IDX_W-1:0]    idx_q;
  logic [bfe_pkg::NW_W-1:0]     ptr;
  logic                         dvalid;
  logic [bfe_pkg::ADDR_W-1:0]   dptr;
  logic [bfe_pkg::CNT_W-1:0]    cnt_acc;
  logic                         hit_q;
  logic [bfe_pkg::IDX_W-1:0]    found_q;
  logic                         bit_value_q;
  logic                         bounds_q;

  logic                         ram_we;
  logic [bfe_pkg::ADDR_W-1:0]   ram_waddr;
  logic [bfe_pkg::WORD_W-1:0]   ram_wdata;
  logic [bfe_pkg::ADDR_W-1:0]   ram_raddr;
  logic [bfe_pkg::WORD_W-1:0]   ram_rdata;

  logic [bfe_pkg::NW_W-1:0]     nwords;
  logic [bfe_pkg::NW_W-1:0]     whole_words;
  logic [bfe_pkg::WORD_W-1:0]   tail_mask;
  logic                         accept;
  logic                         in_single;
  logic                         in_oob;
  logic                         issue;
  logic                         is_find;
  logic [bfe_pkg::WORD_W-1:0]   bit_mask;
  logic [bfe_pkg::WORD_W-1:0]   scan_mask;
  logic [bfe_pkg::WORD_W-1:0]   cand;

  assign whole_words = len[bfe_pkg::LEN_W-1:bfe_pkg::BIT_W];
  assign nwords     = whole_words + {{(bfe_pkg::NW_W-1){1'b0}}, |len[bfe_pkg::BIT_W-1:0]};
  assign tail_mask  = ~({bfe_pkg::WORD_W{1'b1}} << len[bfe_pkg::BIT_W-1:0]);

  assign accept    = in_valid && in_ready;
  assign in_single = req_type <= bfe_pkg::REQ_TEST;
  assign in_oob    = {1'b0, bit_index} >= len;
  assign issue     = ptr < nwords;
  assign is_find   = (req_q == bfe_pkg::REQ_FIND_SET) || (req_q == bfe_pkg::REQ_FIND_CLEAR);
  assign bit_mask  = {{(bfe_pkg::WORD_W-1){1'b0}}, 1'b1} << idx_q[bfe_pkg::BIT_W-1:0];

  // Qualifying bits of the word in flight: only indices below the length.
  assign scan_mask = ({1'b0, dptr} < whole_words) ? {bfe_pkg::WORD_W{1'b1}} : tail_mask;
  assign cand      = ((req_q == bfe_pkg::REQ_FIND_SET) ? ram_rdata : ~ram_rdata) & scan_mask;

  bfe_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_q[bfe_pkg::IDX_W-1:bfe_pkg::BIT_W];
    ram_wdata  = ram_rdata;
    ram_raddr  = idx_q[bfe_pkg::IDX_W-1:bfe_pkg::BIT_W];
    unique case (state)
      bfe_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_single) begin
            state_next = in_oob ? bfe_pkg::S_DONE : bfe_pkg::S_READ;
          end else if (req_type == bfe_pkg::REQ_SET_ALL ||
                       req_type == bfe_pkg::REQ_CLEAR_ALL) begin
            state_next = (nwords == '0) ? bfe_pkg::S_DONE : bfe_pkg::S_BULK;
          end else if (req_type == bfe_pkg::REQ_COUNT_SET ||
                       req_type == bfe_pkg::REQ_COUNT_CLEAR ||
                       req_type == bfe_pkg::REQ_FIND_SET ||
                       req_type == bfe_pkg::REQ_FIND_CLEAR) begin
            state_next = bfe_pkg::S_SCAN;
          end else begin
            state_next = bfe_pkg::S_DONE;
          end
        end
      end
      bfe_pkg::S_READ: begin
        state_next = bfe_pkg::S_MODIFY;
      end
      bfe_pkg::S_MODIFY: begin
        ram_we = req_q != bfe_pkg::REQ_TEST;
        unique case (req_q)
          bfe_pkg::REQ_SET:    ram_wdata = ram_rdata | bit_mask;
          bfe_pkg::REQ_CLEAR:  ram_wdata = ram_rdata & ~bit_mask;
          bfe_pkg::REQ_TOGGLE: ram_wdata = ram_rdata ^ bit_mask;
          default:             ram_wdata = ram_rdata;
        endcase
        state_next = bfe_pkg::S_DONE;
      end
      bfe_pkg::S_BULK: begin
        ram_we    = 1'b1;
        ram_waddr = ptr[bfe_pkg::ADDR_W-1:0];
        if (req_q == bfe_pkg::REQ_SET_ALL) begin
          ram_wdata = (ptr < whole_words) ? {bfe_pkg::WORD_W{1'b1}} : tail_mask;
        end else begin
          ram_wdata = '0;
        end
        if (ptr == nwords - 1'b1) begin
          state_next = bfe_pkg::S_DONE;
        end
      end
      bfe_pkg::S_SCAN: begin
        ram_raddr = ptr[bfe_pkg::ADDR_W-1:0];
        if (!issue && !dvalid) begin
          state_next = bfe_pkg::S_DONE;
        end
      end
      bfe_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = bfe_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bfe_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= 1'b0;
    end else begin
      dvalid <= (state == bfe_pkg::S_SCAN) && issue;
    end
  end

  always_ff @(posedge clk) begin
    dptr <= ptr[bfe_pkg::ADDR_W-1:0];
    if (accept) begin
      req_q       <= req_type;
      idx_q       <= bit_index;
      ptr         <= '0;
      cnt_acc     <= '0;
      hit_q       <= 1'b0;
      found_q     <= '0;
      bit_value_q <= 1'b0;
      bounds_q    <= in_single && in_oob;
    end else begin
      if (state == bfe_pkg::S_BULK || (state == bfe_pkg::S_SCAN && issue)) begin
        ptr <= ptr + 1'b1;
      end
      if (state == bfe_pkg::S_MODIFY && req_q == bfe_pkg::REQ_TEST) begin
        bit_value_q <= ram_rdata[idx_q[bfe_pkg::BIT_W-1:0]];
      end
      if (dvalid) begin
        // The set count covers whole words, stale bits above the length included.
        cnt_acc <= cnt_acc + {{(bfe_pkg::CNT_W-bfe_pkg::POP_W){1'b0}}, pop32(ram_rdata)};
        if (!hit_q && (|cand)) begin
          hit_q   <= 1'b1;
          found_q <= {dptr, lowest(cand)};
        end
      end
    end
  end

  always_comb begin
    res = '0;
    if (bounds_q) begin
      res.status = bfe_pkg::ST_BOUNDS;
    end else if (is_find && !hit_q) begin
      res.status = bfe_pkg::ST_NOTFOUND;
    end else begin
      res.status = bfe_pkg::ST_OK;
    end
    res.bit_value = bit_value_q;
    if (req_q == bfe_pkg::REQ_COUNT_SET) begin
      res.bit_count = cnt_acc;
    end else if (req_q == bfe_pkg::REQ_COUNT_CLEAR) begin
      res.bit_count = (len > cnt_acc) ? len - cnt_acc : '0;
    end
    if (is_find && hit_q) begin
      res.found_index = found_q;
    end
  end

  `BFE_ASSERT_NOW(a_write_state, clk, rst, ram_we,
    (state == bfe_pkg::S_MODIFY || state == bfe_pkg::S_BULK),
    "memory written outside a modify or bulk step")
  `BFE_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accept, (state != bfe_pkg::S_IDLE),
    "item accepted but engine stayed idle")
  `BFE_ASSERT_NOW(a_scan_ptr_range, clk, rst, (state == bfe_pkg::S_SCAN), (ptr <= nwords),
    "scan pointer ran past the covering words")
  `BFE_ASSERT_NEXT(a_result_to_idle, clk, rst, (res_valid && res_ready),
    (state == bfe_pkg::S_IDLE), "engine did not return to idle after its result")

endmodule

// ===== hdl/bfe_obuf.sv =====
`timescale 1ns / 1ps

module bfe_obuf (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       res_valid,
  output logic                       res_ready,
  input  bfe_pkg::res_t              res,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic                       bit_value,
  output logic [bfe_pkg::CNT_W-1:0]  bit_count,
  output logic [bfe_pkg::IDX_W-1:0]  found_index
);

  bfe_pkg::res_t hold;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      hold <= res;
    end
  end

  assign status      = hold.status;
  assign bit_value   = hold.bit_value;
  assign bit_count   = hold.bit_count;
  assign found_index = hold.found_index;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bfe_pkg::*;

  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int PHASES         = 12;
  // A negative entry picks a random length for that phase.
  localparam int PHASE_LEN [PHASES] = '{1024, 1, 0, 2047, 33, 32, 31, 1023, 100, -1, -1, 64};

  localparam logic [3:0] REQ_UNKNOWN_LO = 4'd10;
  localparam logic [3:0] REQ_UNKNOWN_HI = 4'd15;

  typedef struct {
    logic [3:0]       kind;
    logic [IDX_W-1:0] index;
  } flag_req_t;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             cfg_wr_en   = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  logic [3:0]       req_type    = '0;
  logic [IDX_W-1:0] bit_index   = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  logic [1:0]       status;
  logic             bit_value;
  logic [CNT_W-1:0] bit_count;
  logic [IDX_W-1:0] found_index;

  flag_req_t         pending_reqs[$];
  res_t              expected_results[$];
  logic [WORD_W-1:0] flag_store [WORDS];
  logic [LEN_W-1:0]  store_len;

  bit idle_on       = 1'b1;
  bit squeeze_start = 1'b0;
  bit req_taken     = 1'b0;
  int squeeze_left  = 0;
  int in_gap        = 0;
  int out_gap       = 0;
  int stall_cycles  = 0;
  int fail_count    = 0;
  int checked       = 0;

  bitmap_flag_engine i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .bit_index   (bit_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .bit_value   (bit_value),
    .bit_count   (bit_count),
    .found_index (found_index)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one request to the local copy of the flag store and returns its result.
  function automatic res_t apply_flag_req(input logic [3:0] kind, input logic [IDX_W-1:0] index);
    res_t r;
    int   len;
    int   set_bits;
    int   w;
    logic want;
    r = '0;
    len = (store_len > MAX_BITS) ? MAX_BITS : int'(store_len);
    case (kind)
      REQ_SET, REQ_CLEAR, REQ_TOGGLE, REQ_TEST: begin
        if (index >= len) begin
          r.status = ST_BOUNDS;
        end else begin
          w = index / WORD_W;
          case (kind)
            REQ_SET:    flag_store[w][index[BIT_W-1:0]] = 1'b1;
            REQ_CLEAR:  flag_store[w][index[BIT_W-1:0]] = 1'b0;
            REQ_TOGGLE: flag_store[w][index[BIT_W-1:0]] = ~flag_store[w][index[BIT_W-1:0]];
            default:    r.bit_value = flag_store[w][index[BIT_W-1:0]];
          endcase
        end
      end
      REQ_SET_ALL: begin
        for (int i = 0; i < len / WORD_W; i++) flag_store[i] = '1;
        // The partial last word keeps only its valid low bits.
        if (len % WORD_W != 0) flag_store[len / WORD_W] = (32'd1 << (len % WORD_W)) - 32'd1;
      end
      REQ_CLEAR_ALL: begin
        for (int i = 0; i < (len + WORD_W - 1) / WORD_W; i++) flag_store[i] = '0;
      end
      REQ_COUNT_SET, REQ_COUNT_CLEAR: begin
        // Stale bits above the length still count inside the covering words.
        set_bits = 0;
        for (int i = 0; i < (len + WORD_W - 1) / WORD_W; i++) set_bits += $countones(flag_store[i]);
        if (kind == REQ_COUNT_SET) r.bit_count = CNT_W'(set_bits);
        else r.bit_count = (len > set_bits) ? CNT_W'(len - set_bits) : '0;
      end
      REQ_FIND_SET, REQ_FIND_CLEAR: begin
        want = (kind == REQ_FIND_SET);
        r.status = ST_NOTFOUND;
        for (int i = 0; i < len; i++) begin
          if (flag_store[i / WORD_W][i % WORD_W] == want) begin
            r.status = ST_OK;
            r.found_index = IDX_W'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t tb: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  task automatic queue_req(input logic [3:0] kind, input int index);
    pending_reqs.push_back('{kind, IDX_W'(index)});
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    flag_req_t nxt;
    logic      nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (!in_valid || req_taken) begin
        nv = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          req_type  <= nxt.kind;
          bit_index <= nxt.index;
          nv = 1'b1;
          if (idle_on && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 14);
        end
      end
      req_taken = 1'b0;
      in_valid <= nv;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (squeeze_left > 0) begin
      squeeze_left--;
      out_ready <= 1'b0;
    end else if (squeeze_start) begin
      // Long hold-off so that the engine fills up and stops taking items.
      squeeze_start = 1'b0;
      squeeze_left = SQUEEZE_CYCLES;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 14);
    end
  end

  always @(posedge clk) begin
    res_t want_res;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t tb: result with no request pending, actual status %0d", $time, status);
          fail_count++;
        end else begin
          want_res = expected_results.pop_front();
          checked++;
          check_field("status", want_res.status, status);
          check_field("bit_value", want_res.bit_value, bit_value);
          check_field("bit_count", want_res.bit_count, bit_count);
          check_field("found_index", want_res.found_index, found_index);
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_flag_req(req_type, bit_index));
        req_taken = 1'b1;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb: timeout, no item moved for %0d cycles", STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int         plen;
    int         eff;
    int         n_items;
    int         roll;
    logic [3:0] kind;
    int         index;
    foreach (flag_store[i]) flag_store[i] = '0;
    store_len = LEN_W'(MAX_BITS);
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed requests at the reset length of 1024.
    queue_req(REQ_TEST, 0);
    queue_req(REQ_TEST, 1023);
    queue_req(REQ_SET, 0);
    queue_req(REQ_SET, 1023);
    queue_req(REQ_FIND_SET, 0);
    queue_req(REQ_TOGGLE, 1023);
    queue_req(REQ_TEST, 1023);
    queue_req(REQ_CLEAR, 0);
    queue_req(REQ_FIND_SET, 0);
    queue_req(REQ_FIND_CLEAR, 0);
    queue_req(REQ_COUNT_SET, 0);
    queue_req(REQ_COUNT_CLEAR, 0);
    queue_req(REQ_SET_ALL, 0);
    queue_req(REQ_COUNT_SET, 0);
    queue_req(REQ_COUNT_CLEAR, 0);
    queue_req(REQ_FIND_CLEAR, 0);
    queue_req(REQ_TEST, 1023);
    queue_req(REQ_CLEAR, 512);
    queue_req(REQ_FIND_CLEAR, 1023);
    queue_req(REQ_CLEAR_ALL, 0);
    queue_req(REQ_COUNT_SET, 0);
    queue_req(REQ_UNKNOWN_LO, 1023);
    queue_req(REQ_UNKNOWN_HI, 0);
    queue_req(REQ_TOGGLE, 5);
    queue_req(REQ_TEST, 5);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      plen = (PHASE_LEN[p] < 0) ? $urandom_range(2, 1023) : PHASE_LEN[p];
      @(negedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= LEN_W'(plen);
      store_len = LEN_W'(plen);
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      if (p == 7) squeeze_start = 1'b1;
      if (p >= PHASES - 2) idle_on = 1'b0;
      eff = (plen > MAX_BITS) ? MAX_BITS : plen;
      n_items = (plen <= 1) ? 40 : 150;
      repeat (n_items) begin
        roll = $urandom_range(0, 99);
        if (roll < 15) kind = REQ_SET;
        else if (roll < 27) kind = REQ_CLEAR;
        else if (roll < 42) kind = REQ_TOGGLE;
        else if (roll < 60) kind = REQ_TEST;
        else if (roll < 64) kind = REQ_SET_ALL;
        else if (roll < 68) kind = REQ_CLEAR_ALL;
        else if (roll < 75) kind = REQ_COUNT_SET;
        else if (roll < 80) kind = REQ_COUNT_CLEAR;
        else if (roll < 89) kind = REQ_FIND_SET;
        else if (roll < 97) kind = REQ_FIND_CLEAR;
        else kind = 4'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
        // Mostly in-bounds indices, with some anywhere in the field.
        if (eff > 0 && $urandom_range(0, 9) < 8) index = $urandom_range(0, eff - 1);
        else index = $urandom_range(0, 1023);
        queue_req(kind, index);
      end
    end

    wait_idle();
    $display("tb: %0d results checked over %0d length settings, from 0 up to 2047,",
             checked, PHASES + 1);
    $display("tb: with bulk, count, search, single-bit and unknown requests");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
